@@ sv/clook_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-LOOK scheduler package
// Shared widths, codes and the candidate record used by the slot scan.
// ----------------------------------------------------------------------------
package clook_pkg;

    // Fixed field widths.
    localparam int TRACK_W = 10;
    localparam int TAG_W   = 16;
    localparam int AGE_W   = 16;
    localparam int PEND_W  = 7;

    // Default sizes handed to the top level.
    localparam int CAPACITY_DEF    = 64;
    localparam int TRACK_COUNT_DEF = 1024;

    // Operation codes of an input item.
    typedef enum logic {
        OP_ADD = 1'b0,
        OP_GET = 1'b1
    } opcode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_SERVED = 2'd0,
        ST_ADDED  = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_GET,
        S_DRAIN,
        S_FINISH
    } state_t;

    // One slot seen by the scan, or the best slot found so far.
    typedef struct packed {
        logic               found;
        logic [TRACK_W-1:0] track;
        logic [AGE_W-1:0]   age_gap;
        logic [TAG_W-1:0]   tag;
    } cand_t;

endpackage

@@ sv/clook_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-LOOK slot memory
// Track, tag and arrival stamp of every slot; one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module clook_mem
    import clook_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int IDX_W = 6
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [IDX_W-1:0]   waddr,
    input  logic [TRACK_W-1:0] wtrack,
    input  logic [TAG_W-1:0]   wtag,
    input  logic [AGE_W-1:0]   wage,
    input  logic [IDX_W-1:0]   raddr,
    output logic [TRACK_W-1:0] rtrack,
    output logic [TAG_W-1:0]   rtag,
    output logic [AGE_W-1:0]   rage
);

    logic [TRACK_W-1:0] track_mem [DEPTH];
    logic [TAG_W-1:0]   tag_mem   [DEPTH];
    logic [AGE_W-1:0]   age_mem   [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            track_mem[waddr] <= wtrack;
            tag_mem[waddr]   <= wtag;
            age_mem[waddr]   <= wage;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rtrack <= track_mem[raddr];
        rtag   <= tag_mem[raddr];
        rage   <= age_mem[raddr];
    end

endmodule

@@ sv/clook_cand.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-LOOK candidate tracker
// Compares each scanned slot with the best one so far: lowest track wins,
// and on equal tracks the oldest request wins; ties keep the earlier slot.
// ----------------------------------------------------------------------------
module clook_cand
    import clook_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clr,
    input  logic             upd,
    input  cand_t            cand_in,
    input  logic [IDX_W-1:0] idx_in,
    output cand_t            best,
    output logic [IDX_W-1:0] best_idx
);

    cand_t            best_reg;
    cand_t            best_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             take;

    // Compare the incoming slot against the current best.
    always_comb
    begin
        take = !best_reg.found
            || (cand_in.track < best_reg.track)
            || ((cand_in.track == best_reg.track) && (cand_in.age_gap > best_reg.age_gap));
        best_next = best_reg;
        idx_next  = idx_reg;
        if (clr)
        begin
            best_next.found = 1'b0;
        end
        else if (upd && take)
        begin
            best_next       = cand_in;
            best_next.found = 1'b1;
            idx_next        = idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    assign best     = best_reg;
    assign best_idx = idx_reg;

endmodule

@@ sv/clook_disk_request_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-LOOK disk request scheduler
// Holds pending requests in a slot table and serves them in C-LOOK order.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one item: an add of a
// request (track, request_id) or a get of the next request to serve. The
// output channel (out_valid / out_stall) returns exactly one result item per
// input item: status, served id and track, and the pending count.
// One item is worked on at a time; in_stall is high from acceptance until the
// result has been placed in the output register.
// A get walks every slot of the memory through its single read port, one slot
// a cycle, then passes a drain state before its result is loaded. An add walks
// the valid bits up to the lowest free slot. A get on an empty table or an add
// to a full one goes straight to loading its result. The next item is taken
// once the sequencer is back in idle, which it enters as the result is loaded.
// While the receiver stalls, the finished result waits in the output register
// and a new item may still be accepted; that item completes its work and then
// holds until the output register frees.
// Reset clears all valid bits, the arrival counter, the sweep position and
// the pending count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module clook_disk_request_scheduler_top
    import clook_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int TRACK_COUNT = TRACK_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [TRACK_W-1:0] track,
    input  logic [TAG_W-1:0]   request_id,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [TAG_W-1:0]   served_id,
    output logic [TRACK_W-1:0] served_track,
    output logic [PEND_W-1:0]  pending_count
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int TRK_TOP = (TRACK_COUNT - 1 > (1 << TRACK_W) - 1)
                           ? (1 << TRACK_W) - 1 : TRACK_COUNT - 1;
    localparam logic [TRACK_W-1:0] TRK_MAX  = TRACK_W'(TRK_TOP);
    localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(CAPACITY - 1);

    // Control state.
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [AGE_W-1:0]    arrival_reg, arrival_next;
    logic [TRACK_W-1:0]  sweep_reg, sweep_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers.
    opcode_t             op_reg, op_next;
    logic [TRACK_W-1:0]  trk_reg, trk_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_sv_reg;
    status_t             status_reg, status_next;
    logic [TAG_W-1:0]    sid_reg, sid_next;
    logic [TRACK_W-1:0]  strk_reg, strk_next;
    logic [PEND_W-1:0]   pend_reg, pend_next;

    // Memory and scan signals.
    logic [TRACK_W-1:0]  rd_track;
    logic [TAG_W-1:0]    rd_tag;
    logic [AGE_W-1:0]    rd_age;
    logic                mem_we;
    cand_t               scan_c;
    cand_t               hi_c, all_c, sel_c;
    logic [IDX_W-1:0]    hi_idx, all_idx, sel_idx;
    logic                upd_all, upd_hi;

    logic                accept;
    logic                out_free;
    logic                commit;
    logic                add_ok, get_ok;
    logic [TRACK_W-1:0]  trk_clamped;
    logic [CNT_W+PEND_W-1:0] pend_ext;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == S_FINISH) && out_free;
    assign add_ok   = (op_reg == OP_ADD) && (count_reg != CNT_FULL);
    assign get_ok   = (op_reg == OP_GET) && (count_reg != '0);
    assign in_stall = (state_reg != S_IDLE);

    // Clamp of an out-of-range track.
    assign trk_clamped = (track > TRK_MAX) ? TRK_MAX : track;

    // Slot memory.
    clook_mem #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (idx_reg),
        .wtrack (trk_reg),
        .wtag   (tag_reg),
        .wage   (arrival_reg),
        .raddr  (idx_reg),
        .rtrack (rd_track),
        .rtag   (rd_tag),
        .rage   (rd_age)
    );

    // Scanned slot as a candidate; the age distance is taken modulo 2^16.
    always_comb
    begin
        scan_c.found   = 1'b1;
        scan_c.track   = rd_track;
        scan_c.age_gap = arrival_reg - rd_age;
        scan_c.tag     = rd_tag;
    end

    assign upd_all = rd_vld_reg && rd_sv_reg;
    assign upd_hi  = upd_all && (rd_track >= sweep_reg);

    // Best slot at or above the sweep position.
    clook_cand #(
        .IDX_W (IDX_W)
    ) u_cand_hi (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (accept),
        .upd      (upd_hi),
        .cand_in  (scan_c),
        .idx_in   (rd_idx_reg),
        .best     (hi_c),
        .best_idx (hi_idx)
    );

    // Best slot overall, used when the sweep wraps.
    clook_cand #(
        .IDX_W (IDX_W)
    ) u_cand_all (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (accept),
        .upd      (upd_all),
        .cand_in  (scan_c),
        .idx_in   (rd_idx_reg),
        .best     (all_c),
        .best_idx (all_idx)
    );

    assign sel_c   = hi_c.found ? hi_c : all_c;
    assign sel_idx = hi_c.found ? hi_idx : all_idx;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode_t'(opcode) == OP_ADD)
                    begin
                        state_next = (count_reg == CNT_FULL) ? S_FINISH : S_ADD;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? S_FINISH : S_GET;
                    end
                end
            end
            S_ADD:
            begin
                if (!valid_reg[idx_reg])
                begin
                    state_next = S_FINISH;
                end
            end
            S_GET:
            begin
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and result.
    always_comb
    begin
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        arrival_next   = arrival_reg;
        sweep_next     = sweep_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        trk_next       = trk_reg;
        tag_next       = tag_reg;
        status_next    = status_reg;
        sid_next       = sid_reg;
        strk_next      = strk_reg;
        pend_next      = pend_reg;
        mem_we         = 1'b0;
        rd_vld_next    = (state_reg == S_GET);
        out_valid_next = out_valid_reg && out_stall;

        // Capture the item and restart the slot walk.
        if (accept)
        begin
            op_next  = opcode_t'(opcode);
            trk_next = trk_clamped;
            tag_next = request_id;
            idx_next = '0;
        end

        // Walk to the lowest free slot, or over all slots for a get.
        if ((state_reg == S_ADD) && valid_reg[idx_reg])
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (state_reg == S_GET)
        begin
            idx_next = idx_reg + 1'b1;
        end

        // Commit the state change and load the output register.
        if (commit)
        begin
            out_valid_next = 1'b1;
            sid_next       = '0;
            strk_next      = '0;
            if (op_reg == OP_ADD)
            begin
                if (add_ok)
                begin
                    mem_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    arrival_next        = arrival_reg + 1'b1;
                    count_next          = count_reg + 1'b1;
                    if (count_reg == '0)
                    begin
                        sweep_next = trk_reg;
                    end
                    status_next = ST_ADDED;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            else
            begin
                if (get_ok)
                begin
                    valid_next[sel_idx] = 1'b0;
                    sweep_next          = sel_c.track;
                    count_next          = count_reg - 1'b1;
                    sid_next            = sel_c.tag;
                    strk_next           = sel_c.track;
                    status_next         = ST_SERVED;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            pend_ext  = {{PEND_W{1'b0}}, count_next};
            pend_next = pend_ext[PEND_W-1:0];
        end
        else
        begin
            pend_ext = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            arrival_reg   <= '0;
            sweep_reg     <= '0;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            arrival_reg   <= arrival_next;
            sweep_reg     <= sweep_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        trk_reg    <= trk_next;
        tag_reg    <= tag_next;
        rd_idx_reg <= idx_reg;
        rd_sv_reg  <= valid_reg[idx_reg];
        status_reg <= status_next;
        sid_reg    <= sid_next;
        strk_reg   <= strk_next;
        pend_reg   <= pend_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign served_id     = sid_reg;
    assign served_track  = strk_reg;
    assign pending_count = pend_reg;

endmodule

@@ sv/clook_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-LOOK scheduler checker
// Port-level properties of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module clook_checker
    import clook_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic [TAG_W-1:0]   served_id,
    input logic [TRACK_W-1:0] served_track,
    input logic [PEND_W-1:0]  pending_count
);

    localparam logic [PEND_W-1:0] PEND_FULL = PEND_W'(CAPACITY);

    // One item at a time: the block stalls right after taking an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item was in progress");

    // Only a served request reports an id and a track.
    a_zero_when_not_served: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_SERVED)) |-> ((served_id == '0) && (served_track == '0)))
        else $error("served fields not zero on a non-served result");

    // A get on an empty table leaves nothing pending.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |-> (pending_count == '0))
        else $error("empty status with requests pending");

    // A rejected add means the table is full.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (pending_count == PEND_FULL))
        else $error("full status with a table that is not full");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(served_id)))
        else $error("stalled result changed");

endmodule

bind clook_disk_request_scheduler_top clook_checker #(.CAPACITY(CAPACITY)) u_clook_checker (.*);
